/* rtl/core/motor_saturation_duration_monitor_macros.svh */
// Assertion macros shared by the saturation monitor checker.
`ifndef MOTOR_SATURATION_DURATION_MONITOR_MACROS_SVH
`define MOTOR_SATURATION_DURATION_MONITOR_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define MSDM_ASSERT_RST(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is checked at every clock edge, reset included.
`define MSDM_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/msdm_pkg.sv */
// Types and constants of the motor saturation duration monitor.
`timescale 1ns / 1ps

package msdm_pkg;

  // Widths of the stream payloads and of the fields inside them.
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned IN_FIELDS  = 4;
  localparam int unsigned S_TDATA_W  = TIME_W + IN_FIELDS * VALUE_W;
  localparam int unsigned M_TDATA_W  = 8;
  localparam int unsigned RESULT_W   = 4;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UPPER_LIMIT   = 3'd0,
    CFG_LOWER_LIMIT   = 3'd1,
    CFG_WARN_TIME     = 3'd2,
    CFG_MARGIN_TIME   = 3'd3,
    CFG_CRITICAL_TIME = 3'd4
  } cfg_idx_e;

  // Values the registers take at reset.
  localparam logic [VALUE_W-1:0] UPPER_LIMIT_RST   = 16'd1950;
  localparam logic [VALUE_W-1:0] LOWER_LIMIT_RST   = 16'd1050;
  localparam logic [TIME_W-1:0]  WARN_TIME_RST     = 32'd300000;
  localparam logic [TIME_W-1:0]  MARGIN_TIME_RST   = 32'd600000;
  localparam logic [TIME_W-1:0]  CRITICAL_TIME_RST = 32'd1000000;

  // Severity codes of the result.
  typedef enum logic [1:0] {
    SEV_INFO     = 2'd0,
    SEV_WARN     = 2'd1,
    SEV_CRITICAL = 2'd2
  } sev_e;

  // Result item, healthy in the lowest bit.
  typedef struct packed {
    logic margin;
    sev_e severity;
    logic healthy;
  } result_t;

  localparam result_t RESULT_RST = '{margin: 1'b0, severity: SEV_INFO, healthy: 1'b1};

  // Debounced levels of one motor after the current item.
  typedef struct packed {
    logic warn;
    logic margin;
    logic critical;
  } lane_flags_t;

endpackage

/* rtl/core/msdm_lane.sv */
// One motor lane: held value, saturation onset time and the three debounced levels.
`timescale 1ns / 1ps

module msdm_lane (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic                         load_i,
  input  logic [msdm_pkg::VALUE_W-1:0] value_i,
  input  logic [msdm_pkg::TIME_W-1:0]  time_i,
  input  logic [msdm_pkg::VALUE_W-1:0] upper_limit_i,
  input  logic [msdm_pkg::VALUE_W-1:0] lower_limit_i,
  input  logic [msdm_pkg::TIME_W-1:0]  warn_time_i,
  input  logic [msdm_pkg::TIME_W-1:0]  margin_time_i,
  input  logic [msdm_pkg::TIME_W-1:0]  critical_time_i,
  output msdm_pkg::lane_flags_t        flags_o
);

  import msdm_pkg::*;

  logic [VALUE_W-1:0] held_q, held_d;
  logic               pending_q;
  logic [TIME_W-1:0]  start_q, start_d;
  lane_flags_t        levels_q, levels_d;
  logic               sat;
  logic [TIME_W-1:0]  elapsed;

  // Saturation check on the value this item sees, then the duration test.
  always_comb begin
    held_d   = load_i ? value_i : held_q;
    sat      = (held_d >= upper_limit_i) || (held_d <= lower_limit_i);
    start_d  = pending_q ? start_q : time_i;
    elapsed  = time_i - start_d;
    levels_d.warn     = sat && (levels_q.warn     || (elapsed >= warn_time_i));
    levels_d.margin   = sat && (levels_q.margin   || (elapsed >= margin_time_i));
    levels_d.critical = sat && (levels_q.critical || (elapsed >= critical_time_i));
  end

  assign flags_o = levels_d;

  // Lane state advances once per accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q    <= '0;
      pending_q <= 1'b0;
      start_q   <= '0;
      levels_q  <= '0;
    end else if (step_i) begin
      held_q    <= held_d;
      pending_q <= sat;
      levels_q  <= levels_d;
      if (sat) begin
        start_q <= start_d;
      end
    end
  end

endmodule

/* rtl/core/msdm_merge.sv */
// Merging stage: combines the lane levels into severity and margin and holds the result.
`timescale 1ns / 1ps

module msdm_merge #(
  parameter int unsigned MOTORS = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic                  fresh_i,
  input  msdm_pkg::lane_flags_t flags_i [MOTORS],
  output msdm_pkg::result_t     result_o
);

  import msdm_pkg::*;

  logic    warn_seen, margin_seen, crit_seen;
  result_t fresh_result;
  result_t held_q;

  // OR the lane levels together.
  always_comb begin
    warn_seen   = 1'b0;
    margin_seen = 1'b0;
    crit_seen   = 1'b0;
    for (int i = 0; i < MOTORS; i++) begin
      warn_seen   = warn_seen   | flags_i[i].warn;
      margin_seen = margin_seen | (flags_i[i].warn & flags_i[i].margin);
      crit_seen   = crit_seen   | flags_i[i].critical;
    end
  end

  // Build the result a fresh item would publish.
  always_comb begin
    fresh_result = RESULT_RST;
    if (crit_seen || warn_seen) begin
      fresh_result.healthy  = 1'b0;
      fresh_result.severity = crit_seen ? SEV_CRITICAL : SEV_WARN;
      fresh_result.margin   = margin_seen;
    end
  end

  assign result_o = fresh_i ? fresh_result : held_q;

  // Only fresh items replace the published result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= RESULT_RST;
    end else if (step_i && fresh_i) begin
      held_q <= fresh_result;
    end
  end

endmodule

/* rtl/core/motor_saturation_duration_monitor.sv */
// Top level of the motor saturation duration monitor.
`timescale 1ns / 1ps

// Usage:
// The input stream carries one sample per item: tdata holds the microsecond
// timestamp and the motor output values, tuser flags a fresh sample. Each
// motor runs in its own lane, which checks saturation against the limits and
// debounces the warn, margin-low and critical levels over time. A merging
// stage ORs the lanes and, on fresh items only, recomputes the result.
// Every input item yields exactly one result item on the output stream.
// The result is registered: an item accepted while the output is empty
// is valid in the next cycle. One item is accepted every cycle while
// ready is high; each lane does a limit compare, subtract and time compare.
// The output side is a register plus one skid entry, so an item is still
// taken while a result waits; input ready drops only when both are full.
// Reset clears the lanes, restores the register defaults and the held
// result (healthy, info, margin flag clear), and empties the output buffer.
// Configuration writes take effect at the next edge; the user must make them while idle, the block does not enforce it.

module motor_saturation_duration_monitor #(
  parameter int unsigned MOTORS = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: time_us [31:0], motor0_value .. motor3_value [47:32] .. [95:80]
  input  logic [msdm_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // tuser: fresh_sample [0]
  input  logic                            s_axis_tuser,
  // Output stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: healthy [0], severity [2:1], margin [3], zero [7:4]
  output logic [msdm_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // Configuration write port.
  input  logic                            cfg_we_i,
  input  logic [msdm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [msdm_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import msdm_pkg::*;

  logic [VALUE_W-1:0] upper_limit_q, lower_limit_q;
  logic [TIME_W-1:0]  warn_time_q, margin_time_q, critical_time_q;
  logic               accept;
  logic [TIME_W-1:0]  time_us;
  lane_flags_t        lane_flags [MOTORS];
  result_t            result;
  logic               out_valid_q, skid_valid_q;
  result_t            out_data_q, skid_data_q;
  logic               out_fire;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_limit_q   <= UPPER_LIMIT_RST;
      lower_limit_q   <= LOWER_LIMIT_RST;
      warn_time_q     <= WARN_TIME_RST;
      margin_time_q   <= MARGIN_TIME_RST;
      critical_time_q <= CRITICAL_TIME_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_UPPER_LIMIT:   upper_limit_q   <= cfg_data_i[VALUE_W-1:0];
        CFG_LOWER_LIMIT:   lower_limit_q   <= cfg_data_i[VALUE_W-1:0];
        CFG_WARN_TIME:     warn_time_q     <= cfg_data_i[TIME_W-1:0];
        CFG_MARGIN_TIME:   margin_time_q   <= cfg_data_i[TIME_W-1:0];
        CFG_CRITICAL_TIME: critical_time_q <= cfg_data_i[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign time_us = s_axis_tdata[TIME_W-1:0];

  // One lane per motor; motors without an input field keep a zero value.
  for (genvar g = 0; g < MOTORS; g++) begin : g_lane
    logic               lane_load;
    logic [VALUE_W-1:0] lane_value;

    if (g < IN_FIELDS) begin : g_fed
      assign lane_load  = s_axis_tuser;
      assign lane_value = s_axis_tdata[TIME_W + g*VALUE_W +: VALUE_W];
    end else begin : g_unfed
      assign lane_load  = 1'b0;
      assign lane_value = '0;
    end

    msdm_lane u_lane (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .step_i          (accept),
      .load_i          (lane_load),
      .value_i         (lane_value),
      .time_i          (time_us),
      .upper_limit_i   (upper_limit_q),
      .lower_limit_i   (lower_limit_q),
      .warn_time_i     (warn_time_q),
      .margin_time_i   (margin_time_q),
      .critical_time_i (critical_time_q),
      .flags_o         (lane_flags[g])
    );
  end

  msdm_merge #(
    .MOTORS (MOTORS)
  ) u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (accept),
    .fresh_i  (s_axis_tuser),
    .flags_i  (lane_flags),
    .result_o (result)
  );

  // Output register with one skid entry.
  assign s_axis_tready = !skid_valid_q;
  assign out_fire      = out_valid_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_fire) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else if (!accept) begin
        out_valid_q <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_q) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // Payload follows the same routing as the valid bits.
  always_ff @(posedge clk_i) begin
    if (out_fire) begin
      if (skid_valid_q) begin
        out_data_q <= skid_data_q;
      end else if (accept) begin
        out_data_q <= result;
      end
    end else if (accept) begin
      if (!out_valid_q) begin
        out_data_q <= result;
      end else begin
        skid_data_q <= result;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(M_TDATA_W - RESULT_W){1'b0}}, out_data_q};

endmodule

/* rtl/core/msdm_checker.sv */
// Port-level checker for the motor saturation duration monitor, bound to the top level.
`timescale 1ns / 1ps
`include "motor_saturation_duration_monitor_macros.svh"

module msdm_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [msdm_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  import msdm_pkg::*;

  // A stalled output item holds its payload.
  `MSDM_ASSERT_RST(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output item changed while stalled")

  // An item accepted while the output is empty shows up in the next cycle.
  `MSDM_ASSERT_RST(a_one_cycle, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> m_axis_tvalid, "accepted item did not reach the output")

  // Severity only takes the info, warn or critical code.
  `MSDM_ASSERT_ALWAYS(a_sev_legal, clk_i, m_axis_tvalid |-> (m_axis_tdata[2:1] == SEV_INFO) || (m_axis_tdata[2:1] == SEV_WARN) || (m_axis_tdata[2:1] == SEV_CRITICAL), "illegal severity code")

  // Healthy is set exactly when severity is info.
  `MSDM_ASSERT_ALWAYS(a_healthy, clk_i, m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[2:1] == SEV_INFO)), "healthy disagrees with severity")

  // Low margin only comes with a raised severity.
  `MSDM_ASSERT_ALWAYS(a_margin, clk_i, m_axis_tvalid && m_axis_tdata[3] |-> !m_axis_tdata[0], "low margin on a healthy result")

endmodule

bind motor_saturation_duration_monitor msdm_checker u_msdm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
